>>> sv/cbba_pkg.sv
// shared constants, field widths and control/status structs for the
// contiguous block bitmap allocator; no dependencies
package cbba_pkg;

    localparam int NUM_CYLINDERS_DEF       = 8;
    localparam int TRACKS_PER_CYLINDER_DEF = 32;

    // map word width for the bitmap memory
    localparam int WORD_W = 8;
    localparam int BIT_W  = 3;

    localparam int CNT_W = 9;
    localparam int CYL_W = 4;
    localparam int TRK_W = 5;
    localparam int REC_W = 8;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FAIL = 1'b1;

    typedef struct packed {
        logic load;
        logic clr_step;
        logic scan_start;
        logic scan_step;
        logic mark_start;
        logic mark_step;
        logic free_start;
        logic free_step;
        logic out_ld;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_free;
        logic alloc_bad;
        logic free_bad;
        logic scan_hit;
        logic last_word;
        logic mark_last;
        logic free_stop;
    } dp_status_t;

endpackage

>>> sv/cbba_if.sv
// request and response channel interfaces (valid/ready with payload)
// depends on cbba_pkg for the field widths
interface cbba_req_if;
    logic                        valid;
    logic                        ready;
    logic                        command;
    logic [cbba_pkg::CNT_W-1:0]  block_count;
    logic [cbba_pkg::CYL_W-1:0]  start_cylinder;
    logic [cbba_pkg::TRK_W-1:0]  start_track;
    logic [cbba_pkg::REC_W-1:0]  first_record;

    modport source (output valid, command, block_count, start_cylinder, start_track,
                    first_record, input ready);
    modport sink   (input valid, command, block_count, start_cylinder, start_track,
                    first_record, output ready);
endinterface

interface cbba_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        status;
    logic [cbba_pkg::REC_W-1:0]  run_start;
    logic [cbba_pkg::CNT_W-1:0]  blocks_done;

    modport source (output valid, status, run_start, blocks_done, input ready);
    modport sink   (input valid, status, run_start, blocks_done, output ready);
endinterface

>>> sv/contiguous_block_bitmap_allocator.sv
// top level of the first-fit contiguous bitmap allocator
// depends on cbba_pkg, cbba_if, cbba_ctrl and cbba_datapath
//
//   channel  role    fields
//   req      sink    command, block_count, start_cylinder, start_track, first_record
//   rsp      source  status, run_start, blocks_done
//
// the map is held as 8-bit words in one memory, one word read and one written per cycle
// allocate: scan from word 0 to the granted run, then mark the words the run spans
// free: release from the record's word until a gap, the count or the map end
// rejected commands go straight to the response; after reset a clearing pass over every
// map word runs before the first request is taken
// the result sits in an output register; a new request is taken while it waits
module contiguous_block_bitmap_allocator #(
    parameter int NUM_CYLINDERS       = cbba_pkg::NUM_CYLINDERS_DEF,
    parameter int TRACKS_PER_CYLINDER = cbba_pkg::TRACKS_PER_CYLINDER_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    cbba_req_if.sink   req,
    cbba_rsp_if.source rsp
);

    cbba_pkg::ctrl_cmd_t  cmd;
    cbba_pkg::dp_status_t status;

    cbba_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .status    (status),
        .cmd       (cmd)
    );

    cbba_datapath #(
        .NUM_CYLINDERS       (NUM_CYLINDERS),
        .TRACKS_PER_CYLINDER (TRACKS_PER_CYLINDER)
    ) u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .command        (req.command),
        .block_count    (req.block_count),
        .start_cylinder (req.start_cylinder),
        .start_track    (req.start_track),
        .first_record   (req.first_record),
        .rsp_status     (rsp.status),
        .run_start      (rsp.run_start),
        .blocks_done    (rsp.blocks_done)
    );

endmodule

>>> sv/cbba_ctrl.sv
// sequencing state machine for the bitmap allocator
// depends on cbba_pkg for the command and status structs
module cbba_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    input  cbba_pkg::dp_status_t status,
    output cbba_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [9:0] {
        S_CLEAR  = 10'b00_0000_0001,
        S_IDLE   = 10'b00_0000_0010,
        S_DECODE = 10'b00_0000_0100,
        S_A_RD   = 10'b00_0000_1000,
        S_A_SCAN = 10'b00_0001_0000,
        S_M_RD   = 10'b00_0010_0000,
        S_M_WR   = 10'b00_0100_0000,
        S_F_RD   = 10'b00_1000_0000,
        S_F_WR   = 10'b01_0000_0000,
        S_RESP   = 10'b10_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (status.last_word)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                priority if (status.is_free)
                begin
                    state_next = status.free_bad ? S_RESP : S_F_RD;
                end
                else
                begin
                    state_next = status.alloc_bad ? S_RESP : S_A_RD;
                end
            end
            S_A_RD:
            begin
                cmd.scan_start = 1'b1;
                state_next     = S_A_SCAN;
            end
            S_A_SCAN:
            begin
                cmd.scan_step = 1'b1;
                priority if (status.scan_hit)
                begin
                    state_next = S_M_RD;
                end
                else if (status.last_word)
                begin
                    state_next = S_RESP;
                end
            end
            S_M_RD:
            begin
                cmd.mark_start = 1'b1;
                state_next     = S_M_WR;
            end
            S_M_WR:
            begin
                cmd.mark_step = 1'b1;
                if (status.mark_last)
                begin
                    state_next = S_RESP;
                end
            end
            S_F_RD:
            begin
                cmd.free_start = 1'b1;
                state_next     = S_F_WR;
            end
            S_F_WR:
            begin
                cmd.free_step = 1'b1;
                if (status.free_stop || status.last_word)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                // wait for the output register to drain
                if (!out_valid_reg || rsp_ready)
                begin
                    cmd.out_ld     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = out_valid_reg;

endmodule

>>> sv/cbba_datapath.sv
// bitmap memory, word scan/mark/release logic and result registers
// depends on cbba_pkg; driven by cbba_ctrl
module cbba_datapath #(
    parameter int NUM_CYLINDERS       = cbba_pkg::NUM_CYLINDERS_DEF,
    parameter int TRACKS_PER_CYLINDER = cbba_pkg::TRACKS_PER_CYLINDER_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  cbba_pkg::ctrl_cmd_t         cmd,
    output cbba_pkg::dp_status_t        status,
    input  logic                        command,
    input  logic [cbba_pkg::CNT_W-1:0]  block_count,
    input  logic [cbba_pkg::CYL_W-1:0]  start_cylinder,
    input  logic [cbba_pkg::TRK_W-1:0]  start_track,
    input  logic [cbba_pkg::REC_W-1:0]  first_record,
    output logic                        rsp_status,
    output logic [cbba_pkg::REC_W-1:0]  run_start,
    output logic [cbba_pkg::CNT_W-1:0]  blocks_done
);

    localparam int WORD_W = cbba_pkg::WORD_W;
    localparam int BIT_W  = cbba_pkg::BIT_W;
    localparam int REC_W  = cbba_pkg::REC_W;
    localparam int CNT_W  = cbba_pkg::CNT_W;
    localparam int CYL_W  = cbba_pkg::CYL_W;
    localparam int TRK_W  = cbba_pkg::TRK_W;
    localparam int TOTAL  = NUM_CYLINDERS * TRACKS_PER_CYLINDER;
    localparam int NWORDS = (TOTAL + WORD_W - 1) / WORD_W;
    localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int PW     = (AW + BIT_W + 1 > 10) ? (AW + BIT_W + 1) : 10;

    localparam logic [PW-1:0] TOTAL_P = PW'(TOTAL);
    localparam logic [PW-1:0] NCYL_P  = PW'(NUM_CYLINDERS);
    localparam logic [PW-1:0] NTRK_P  = PW'(TRACKS_PER_CYLINDER);
    localparam logic [AW-1:0] LAST_W  = AW'(NWORDS - 1);

    logic [WORD_W-1:0] mem [NWORDS];
    logic [WORD_W-1:0] rd_data_reg;

    logic [AW-1:0]     ptr_reg;
    logic [AW-1:0]     ptr_next;
    logic              cmd_reg;
    logic [PW-1:0]     want_reg;
    logic [CYL_W-1:0]  cyl_reg;
    logic [TRK_W-1:0]  trk_reg;
    logic [REC_W-1:0]  rec_reg;
    logic [PW-1:0]     run_reg;
    logic [PW-1:0]     count_reg;
    logic [PW-1:0]     first_reg;
    logic [PW-1:0]     end_reg;
    logic              first_word_reg;
    logic              res_status_reg;
    logic [REC_W-1:0]  res_start_reg;
    logic [CNT_W-1:0]  res_done_reg;
    logic              out_status_reg;
    logic [REC_W-1:0]  out_start_reg;
    logic [CNT_W-1:0]  out_done_reg;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              last_word;
    logic [AW-1:0]     ptr_inc;

    logic [PW-1:0]     scan_run;
    logic              scan_hit;
    logic [PW-1:0]     hit_pos;
    logic [PW-1:0]     hit_first;
    logic [WORD_W-1:0] mark_word;
    logic [WORD_W-1:0] free_word;
    logic [PW-1:0]     free_cnt;
    logic              free_stop;
    logic              free_ok;
    logic [PW-1:0]     scan_origin;
    logic [PW-1:0]     trk_clamp;
    logic [PW-1:0]     rec_ext;

    assign last_word = (ptr_reg == LAST_W);
    assign ptr_inc   = last_word ? '0 : ptr_reg + AW'(1);
    assign rec_ext   = PW'(rec_reg);

    // free scan origin: cylinder * tracks + track, track clamped to the cylinder edge
    assign trk_clamp   = (PW'(trk_reg) > NTRK_P) ? NTRK_P : PW'(trk_reg);
    assign scan_origin = PW'(PW'(cyl_reg) * NTRK_P) + trk_clamp;

    // allocate: extend the free run across one map word
    always_comb
    begin
        logic [PW-1:0] run;
        logic [PW-1:0] pos;
        logic          hit;
        run = run_reg;
        hit = 1'b0;
        pos = '0;
        hit_pos = '0;
        for (int j = 0; j < WORD_W; j++)
        begin
            pos = PW'({ptr_reg, BIT_W'(j)});
            if (!hit)
            begin
                run = (!rd_data_reg[j] && (pos < TOTAL_P)) ? run + PW'(1) : '0;
                if (run == want_reg)
                begin
                    hit     = 1'b1;
                    hit_pos = pos;
                end
            end
        end
        scan_run = run;
        scan_hit = hit;
    end

    assign hit_first = hit_pos + PW'(1) - want_reg;

    // allocate: set the bits of the granted run that fall in this word
    always_comb
    begin
        logic [PW-1:0] pos;
        pos = '0;
        mark_word = rd_data_reg;
        for (int j = 0; j < WORD_W; j++)
        begin
            pos = PW'({ptr_reg, BIT_W'(j)});
            if ((pos >= first_reg) && (pos <= end_reg))
            begin
                mark_word[j] = 1'b1;
            end
        end
    end

    // free: release consecutive allocated blocks until a gap or the count is met
    always_comb
    begin
        logic          act;
        logic          ok;
        logic [PW-1:0] cnt;
        logic [PW-1:0] pos;
        act = 1'b1;
        ok  = 1'b0;
        cnt = count_reg;
        pos = '0;
        free_word = rd_data_reg;
        for (int j = 0; j < WORD_W; j++)
        begin
            pos = PW'({ptr_reg, BIT_W'(j)});
            if (act && !(first_word_reg && (BIT_W'(j) < rec_reg[BIT_W-1:0])))
            begin
                if (rd_data_reg[j] && (pos < TOTAL_P))
                begin
                    free_word[j] = 1'b0;
                    cnt = cnt + PW'(1);
                    if (cnt == want_reg)
                    begin
                        act = 1'b0;
                        ok  = 1'b1;
                    end
                end
                else
                begin
                    act = 1'b0;
                end
            end
        end
        free_cnt  = cnt;
        free_stop = !act;
        free_ok   = ok;
    end

    // memory port control
    always_comb
    begin
        wr_en    = 1'b0;
        wr_addr  = ptr_reg;
        wr_data  = '0;
        rd_en    = 1'b0;
        rd_addr  = ptr_inc;
        ptr_next = ptr_reg;
        priority if (cmd.clr_step)
        begin
            wr_en    = 1'b1;
            ptr_next = ptr_inc;
        end
        else if (cmd.scan_start)
        begin
            rd_en    = 1'b1;
            rd_addr  = '0;
            ptr_next = '0;
        end
        else if (cmd.scan_step)
        begin
            rd_en    = !last_word;
            ptr_next = ptr_inc;
        end
        else if (cmd.mark_start)
        begin
            rd_en    = 1'b1;
            rd_addr  = first_reg[AW+BIT_W-1:BIT_W];
            ptr_next = first_reg[AW+BIT_W-1:BIT_W];
        end
        else if (cmd.mark_step)
        begin
            wr_en    = 1'b1;
            wr_data  = mark_word;
            rd_en    = !status.mark_last;
            ptr_next = ptr_inc;
        end
        else if (cmd.free_start)
        begin
            rd_en    = 1'b1;
            rd_addr  = AW'(rec_reg[REC_W-1:BIT_W]);
            ptr_next = AW'(rec_reg[REC_W-1:BIT_W]);
        end
        else if (cmd.free_step)
        begin
            wr_en    = 1'b1;
            wr_data  = free_word;
            rd_en    = !last_word && !free_stop;
            ptr_next = ptr_inc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg <= '0;
        end
        else
        begin
            ptr_reg <= ptr_next;
        end
    end

    // request capture, working registers and result
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg        <= command;
            want_reg       <= PW'(block_count);
            cyl_reg        <= start_cylinder;
            trk_reg        <= start_track;
            rec_reg        <= first_record;
            res_status_reg <= cbba_pkg::ST_FAIL;
            res_start_reg  <= (command == cbba_pkg::CMD_FREE) ? first_record : '0;
            res_done_reg   <= '0;
        end
        if (cmd.scan_start)
        begin
            run_reg <= '0;
        end
        if (cmd.scan_step)
        begin
            run_reg <= scan_run;
            if (scan_hit)
            begin
                first_reg      <= hit_first;
                end_reg        <= hit_pos;
                res_status_reg <= cbba_pkg::ST_OK;
                res_start_reg  <= REC_W'(hit_first);
                res_done_reg   <= CNT_W'(want_reg);
            end
        end
        if (cmd.free_start)
        begin
            count_reg      <= '0;
            first_word_reg <= 1'b1;
        end
        if (cmd.free_step)
        begin
            count_reg      <= free_cnt;
            first_word_reg <= 1'b0;
            res_status_reg <= free_ok ? cbba_pkg::ST_OK : cbba_pkg::ST_FAIL;
            res_done_reg   <= CNT_W'(free_cnt);
        end
        if (cmd.out_ld)
        begin
            out_status_reg <= res_status_reg;
            out_start_reg  <= res_start_reg;
            out_done_reg   <= res_done_reg;
        end
    end

    always_comb
    begin
        status.is_free   = (cmd_reg == cbba_pkg::CMD_FREE);
        status.alloc_bad = (want_reg == '0) || (want_reg > TOTAL_P);
        status.free_bad  = (PW'(cyl_reg) >= NCYL_P) || (scan_origin > rec_ext)
                           || (rec_ext >= TOTAL_P);
        status.scan_hit  = scan_hit;
        status.last_word = last_word;
        status.mark_last = (ptr_reg == end_reg[AW+BIT_W-1:BIT_W]);
        status.free_stop = free_stop;
    end

    assign rsp_status  = out_status_reg;
    assign run_start   = out_start_reg;
    assign blocks_done = out_done_reg;

endmodule

>>> tb/cbba_allocation_checker.sv
// checker for the contiguous block bitmap allocator: watches both channels,
// keeps its own copy of the allocation map and compares every response
// depends on cbba_pkg and the channel interfaces in cbba_if
`timescale 1ns / 100ps

module cbba_allocation_checker #(
    parameter int NUM_CYLINDERS       = cbba_pkg::NUM_CYLINDERS_DEF,
    parameter int TRACKS_PER_CYLINDER = cbba_pkg::TRACKS_PER_CYLINDER_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    cbba_req_if  req,
    cbba_rsp_if  rsp,
    output int   mismatches,
    output int   awaiting
);

    import cbba_pkg::*;

    localparam int TOTAL_BLOCKS = NUM_CYLINDERS * TRACKS_PER_CYLINDER;

    typedef struct packed {
        logic             status;
        logic [REC_W-1:0] run_start;
        logic [CNT_W-1:0] blocks_done;
    } outcome_t;

    logic [TOTAL_BLOCKS-1:0] disk_map;
    outcome_t                outcome_q[$];

    // applies one command to the map copy and returns the response it should give
    function automatic outcome_t apply_command(
        input logic             cmd,
        input logic [CNT_W-1:0] cnt,
        input logic [CYL_W-1:0] cyl,
        input logic [TRK_W-1:0] trk,
        input logic [REC_W-1:0] rec
    );
        outcome_t res;
        int       run;
        int       first;
        int       count;
        int       pos;
        bit       done;
        res.status      = ST_FAIL;
        res.run_start   = '0;
        res.blocks_done = '0;
        done            = 1'b0;
        if (cmd == CMD_ALLOC) begin
            if (cnt != 0 && int'(cnt) <= TOTAL_BLOCKS) begin
                run = 0;
                for (int idx = 0; idx < TOTAL_BLOCKS && !done; idx++) begin
                    if (disk_map[idx]) begin
                        run = 0;
                    end
                    else begin
                        run++;
                        if (run == int'(cnt)) begin
                            first = idx + 1 - int'(cnt);
                            for (int k = first; k <= idx; k++)
                                disk_map[k] = 1'b1;
                            res.status      = ST_OK;
                            res.run_start   = first[REC_W-1:0];
                            res.blocks_done = cnt;
                            done            = 1'b1;
                        end
                    end
                end
            end
        end
        else begin
            res.run_start = rec;
            if (int'(cyl) < NUM_CYLINDERS) begin
                // a track past the cylinder end starts the scan on the next cylinder
                pos   = int'(cyl) * TRACKS_PER_CYLINDER
                      + ((int'(trk) > TRACKS_PER_CYLINDER) ? TRACKS_PER_CYLINDER : int'(trk));
                count = 0;
                for (int idx = pos; idx < TOTAL_BLOCKS && !done; idx++) begin
                    if (disk_map[idx] && idx == int'(rec) + count) begin
                        disk_map[idx] = 1'b0;
                        count++;
                        if (count == int'(cnt)) begin
                            res.status = ST_OK;
                            done       = 1'b1;
                        end
                    end
                end
                res.blocks_done = count[CNT_W-1:0];
            end
        end
        return res;
    endfunction

    task automatic report_field(input string field, input int exp_val, input int got_val);
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_val, got_val);
        mismatches = mismatches + 1;
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        outcome_t want;
        if (!rst_n) begin
            disk_map = '0;
            outcome_q.delete();
            awaiting <= 0;
        end
        else begin
            // responses first: one accepted on this edge belongs to an older transaction
            if (rsp.valid && rsp.ready) begin
                if (outcome_q.size() == 0) begin
                    $display("%0t: response with none expected, status %0b run_start %0d blocks_done %0d",
                             $time, rsp.status, rsp.run_start, rsp.blocks_done);
                    mismatches = mismatches + 1;
                end
                else begin
                    want = outcome_q.pop_front();
                    if (rsp.status !== want.status)
                        report_field("status", want.status, rsp.status);
                    if (rsp.run_start !== want.run_start)
                        report_field("run_start", want.run_start, rsp.run_start);
                    if (rsp.blocks_done !== want.blocks_done)
                        report_field("blocks_done", want.blocks_done, rsp.blocks_done);
                end
            end
            if (req.valid && req.ready)
                outcome_q.push_back(apply_command(req.command, req.block_count,
                                                  req.start_cylinder, req.start_track,
                                                  req.first_record));
            awaiting <= outcome_q.size();
        end
    end

endmodule

>>> tb/contiguous_block_bitmap_allocator_tb.sv
// top of the allocator testbench: clock, reset, command stimulus and verdict
// depends on cbba_pkg, cbba_if, the allocator rtl and cbba_allocation_checker
`timescale 1ns / 100ps

module contiguous_block_bitmap_allocator_tb;

    import cbba_pkg::*;

    localparam int TRACKS           = TRACKS_PER_CYLINDER_DEF;
    localparam int LAST_BLOCK       = NUM_CYLINDERS_DEF * TRACKS - 1;
    localparam int RANDOM_PER_PHASE = 335;
    localparam int LONG_HOLD        = 400;
    localparam int SETTLE_CYCLES    = 100;
    localparam int CYCLE_LIMIT      = 1000000;

    typedef struct packed {
        logic [REC_W-1:0] first;
        logic [CNT_W-1:0] len;
    } run_t;

    logic        clk;
    logic        rst_n;
    int          mismatches;
    int          awaiting;
    int          cycle_count = 0;
    int          tx_mode;
    int          rx_mode;
    int          burst_left;
    int          hold_requests = 0;
    int          holds_served  = 0;
    int          hold_left     = 0;
    logic [15:0] rx_pattern    = 16'b1100_1011_1000_1101;
    logic        issued_q[$];
    run_t        live_runs[$];

    cbba_req_if req_ch();
    cbba_rsp_if rsp_ch();

    contiguous_block_bitmap_allocator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    cbba_allocation_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .mismatches (mismatches),
        .awaiting   (awaiting)
    );

    always begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // response side: long hold-off on request, otherwise always ready, random or a fixed stall pattern
    always @(posedge clk) begin
        if (holds_served != hold_requests) begin
            holds_served  <= holds_served + 1;
            hold_left     <= LONG_HOLD;
            rsp_ch.ready  <= 1'b0;
        end
        else if (hold_left > 0) begin
            hold_left    <= hold_left - 1;
            rsp_ch.ready <= 1'b0;
        end
        else begin
            case (rx_mode)
                1:       rsp_ch.ready <= ($urandom_range(0, 99) >= 35);
                2:       begin
                             rx_pattern   <= {rx_pattern[14:0], rx_pattern[15]};
                             rsp_ch.ready <= rx_pattern[15];
                         end
                default: rsp_ch.ready <= 1'b1;
            endcase
        end
    end

    // granted runs feed the free commands of the random part
    always @(posedge clk) begin : run_tracker
        logic was_alloc;
        if (rst_n && rsp_ch.valid && rsp_ch.ready && issued_q.size() > 0) begin
            was_alloc = (issued_q.pop_front() == CMD_ALLOC);
            if (was_alloc && rsp_ch.status == ST_OK)
                live_runs.push_back(run_t'{rsp_ch.run_start, rsp_ch.blocks_done});
        end
    end

    task automatic send_command(
        input logic             cmd,
        input logic [CNT_W-1:0] cnt,
        input logic [CYL_W-1:0] cyl,
        input logic [TRK_W-1:0] trk,
        input logic [REC_W-1:0] rec
    );
        int gap;
        req_ch.valid          <= 1'b1;
        req_ch.command        <= cmd;
        req_ch.block_count    <= cnt;
        req_ch.start_cylinder <= cyl;
        req_ch.start_track    <= trk;
        req_ch.first_record   <= rec;
        do
            @(posedge clk);
        while (!req_ch.ready);
        issued_q.push_back(cmd);
        if (tx_mode != 0) begin
            if (burst_left > 0) begin
                burst_left--;
            end
            else begin
                gap          = $urandom_range(1, 8);
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
                burst_left = $urandom_range(1, 12);
            end
        end
    endtask

    task automatic free_at(input int pos, input int rec, input int len);
        send_command(CMD_FREE, len, pos / TRACKS, pos % TRACKS, rec);
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (awaiting != 0);
    endtask

    task automatic issue_random_command();
        int   pick;
        int   idx;
        int   pos;
        int   rec;
        int   len;
        run_t run;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            send_command($urandom_range(0, 1), $urandom_range(0, 256), $urandom_range(0, 15),
                         $urandom_range(0, 31), $urandom_range(0, 255));
            return;
        end
        if (pick < 55 || live_runs.size() == 0) begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
                len = $urandom_range(1, 8);
            else if (pick < 85)
                len = $urandom_range(9, 32);
            else if (pick < 97)
                len = $urandom_range(33, 96);
            else
                len = $urandom_range(97, 256);
            send_command(CMD_ALLOC, len, $urandom_range(0, 15), $urandom_range(0, 31),
                         $urandom_range(0, 255));
            return;
        end
        idx = $urandom_range(0, live_runs.size() - 1);
        run = live_runs[idx];
        live_runs.delete(idx);
        pos  = run.first;
        rec  = run.first;
        len  = run.len;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            // exact release of a granted run
        end
        else if (pick < 65) begin
            pos = $urandom_range(0, run.first);
        end
        else if (pick < 75) begin
            len = $urandom_range(1, run.len);
            if (len < run.len) begin
                run.first = run.first + len;
                run.len   = run.len - len;
                live_runs.push_back(run);
            end
        end
        else if (pick < 82) begin
            len = 0;
        end
        else if (pick < 88) begin
            len = run.len + $urandom_range(1, 20);
            if (len > 256)
                len = 256;
        end
        else if (pick < 92) begin
            rec = run.first + $urandom_range(0, run.len - 1);
            pos = $urandom_range(run.first, rec);
            len = $urandom_range(0, run.len);
        end
        else if (run.first < LAST_BLOCK) begin
            // scan starts past the run, nothing is released
            pos = $urandom_range(run.first + 1, LAST_BLOCK);
            live_runs.push_back(run);
        end
        free_at(pos, rec, len);
    endtask

    initial begin
        rst_n                 = 1'b0;
        req_ch.valid          = 1'b0;
        req_ch.command        = CMD_ALLOC;
        req_ch.block_count    = '0;
        req_ch.start_cylinder = '0;
        req_ch.start_track    = '0;
        req_ch.first_record   = '0;
        rsp_ch.ready          = 1'b0;
        tx_mode               = 1;
        rx_mode               = 1;
        burst_left            = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        send_command(CMD_ALLOC, 0, 0, 0, 0);
        send_command(CMD_ALLOC, 256, 0, 0, 0);
        send_command(CMD_ALLOC, 1, 15, 31, 255);
        free_at(0, 0, 256);
        send_command(CMD_ALLOC, 10, 0, 0, 0);
        send_command(CMD_ALLOC, 20, 0, 0, 0);
        send_command(CMD_ALLOC, 40, 0, 0, 0);
        free_at(10, 10, 5);
        send_command(CMD_ALLOC, 3, 0, 0, 0);
        send_command(CMD_ALLOC, 5, 0, 0, 0);
        free_at(0, 0, 0);
        free_at(15, 15, 100);
        send_command(CMD_ALLOC, 32, 0, 0, 0);
        send_command(CMD_ALLOC, 8, 0, 0, 0);
        free_at(40, 5, 1);
        send_command(CMD_FREE, 1, 8, 0, 0);
        send_command(CMD_FREE, 256, 15, 31, 255);
        free_at(LAST_BLOCK, LAST_BLOCK, 1);
        free_at(200, 200, 1);
        send_command(CMD_ALLOC, 256, 0, 0, 0);
        free_at(0, 0, 0);
        drain_results();

        for (int phase = 0; phase < 4; phase++) begin
            tx_mode = (phase == 0 || phase == 3) ? 0 : 1;
            rx_mode = (phase == 0) ? 0 : ((phase == 2) ? 2 : 1);
            // sender keeps offering through the hold-off so the block backs up
            if (phase == 1 || phase == 3)
                hold_requests++;
            repeat (RANDOM_PER_PHASE) issue_random_command();
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> filelist.f
sv/cbba_pkg.sv
sv/cbba_if.sv
sv/cbba_ctrl.sv
sv/cbba_datapath.sv
sv/contiguous_block_bitmap_allocator.sv
tb/cbba_allocation_checker.sv
tb/contiguous_block_bitmap_allocator_tb.sv
